// File: design/rdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_pkg
// shared types and constants of the refcounted descriptor table
// ----------------------------------------------------------------------------
package rdt_pkg;

  // fixed port widths
  localparam int unsigned DESC_PORT_W = 8;
  localparam int unsigned FLAGS_W     = 32;
  localparam int unsigned HASH_PORT_W = 64;
  localparam int unsigned NARROW_W    = 7;

  // free slot search works on groups of this many slots
  localparam int unsigned FS_GRP   = 16;
  localparam int unsigned FS_GRP_W = 4;

  typedef enum logic [2:0] {
    ACT_OPEN   = 3'd0,
    ACT_DUP    = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_SET_EC = 3'd3,
    ACT_CLOSE  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DESC  = 2'd1,
    ST_OPEN_BUSY = 2'd2,
    ST_DUP_BUSY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DESC = 2'd1,
    S_EXEC = 2'd2
  } state_e;

endpackage

// File: design/rdt_desc_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_desc_mem
// per-descriptor memory: slot index and close-on-exec bit, two read ports
// ----------------------------------------------------------------------------
module rdt_desc_mem import rdt_pkg::*; #(
  parameter int unsigned NUM_FDS = 64,
  parameter int unsigned SLOT_W  = 7,
  localparam int unsigned FD_W   = $clog2(NUM_FDS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FD_W-1:0]   rd_a_addr_i,
  input  logic [FD_W-1:0]   rd_b_addr_i,
  output logic [SLOT_W-1:0] rd_a_slot_o,
  output logic              rd_a_ec_o,
  output logic [SLOT_W-1:0] rd_b_slot_o,
  output logic              rd_b_ec_o,
  input  logic              wr_en_i,
  input  logic [FD_W-1:0]   wr_addr_i,
  input  logic [SLOT_W-1:0] wr_slot_i,
  input  logic              wr_ec_i
);

  logic [SLOT_W:0]      mem [NUM_FDS];
  logic [NUM_FDS-1:0]   vld_q;
  logic [SLOT_W:0]      rd_a_q, rd_b_q;
  logic                 rd_a_vld_q, rd_b_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_slot_i, wr_ec_i};
    end
    rd_a_q <= mem[rd_a_addr_i];
    rd_b_q <= mem[rd_b_addr_i];
  end

  // entries never written read as unmapped with a clear bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_a_vld_q <= vld_q[rd_a_addr_i];
      rd_b_vld_q <= vld_q[rd_b_addr_i];
    end
  end

  assign rd_a_slot_o = rd_a_vld_q ? rd_a_q[SLOT_W:1] : '0;
  assign rd_a_ec_o   = rd_a_vld_q & rd_a_q[0];
  assign rd_b_slot_o = rd_b_vld_q ? rd_b_q[SLOT_W:1] : '0;
  assign rd_b_ec_o   = rd_b_vld_q & rd_b_q[0];

endmodule

// File: design/rdt_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_slot_mem
// shared info slots: reference count, flags and path hash, plus busy bits
// ----------------------------------------------------------------------------
module rdt_slot_mem import rdt_pkg::*; #(
  parameter int unsigned NUM_FDS   = 64,
  parameter int unsigned HASH_BITS = 64,
  parameter int unsigned SLOT_W    = 7,
  localparam int unsigned NUM_SLOTS = NUM_FDS + 1,
  localparam int unsigned ENT_W     = SLOT_W + FLAGS_W + HASH_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SLOT_W-1:0]    rd_addr_i,
  output logic [SLOT_W-1:0]    rd_cnt_o,
  output logic [FLAGS_W-1:0]   rd_flags_o,
  output logic [HASH_BITS-1:0] rd_hash_o,
  input  logic                 wr_en_i,
  input  logic [SLOT_W-1:0]    wr_addr_i,
  input  logic [SLOT_W-1:0]    wr_cnt_i,
  input  logic [FLAGS_W-1:0]   wr_flags_i,
  input  logic [HASH_BITS-1:0] wr_hash_i,
  output logic [NUM_SLOTS-1:0] busy_o
);

  logic [ENT_W-1:0]     mem [NUM_SLOTS];
  logic [ENT_W-1:0]     rd_q;
  logic [NUM_SLOTS-1:0] busy_q;
  logic                 rd_busy_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_cnt_i, wr_flags_i, wr_hash_i};
    end
    rd_q <= mem[rd_addr_i];
  end

  // a slot is busy while its count is nonzero; a free slot reads count 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      rd_busy_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        busy_q[wr_addr_i] <= (wr_cnt_i != '0);
      end
      rd_busy_q <= busy_q[rd_addr_i];
    end
  end

  assign rd_cnt_o   = rd_busy_q ? rd_q[ENT_W-1 -: SLOT_W] : '0;
  assign rd_flags_o = rd_q[HASH_BITS +: FLAGS_W];
  assign rd_hash_o  = rd_q[HASH_BITS-1:0];
  assign busy_o     = busy_q;

endmodule

// File: design/rdt_free_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_free_search
// lowest free slot from 1 upward, two-level registered priority search
// ----------------------------------------------------------------------------
module rdt_free_search import rdt_pkg::*; #(
  parameter int unsigned NUM_FDS = 64,
  parameter int unsigned SLOT_W  = 7,
  localparam int unsigned NUM_SLOTS = NUM_FDS + 1,
  localparam int unsigned NGRP      = (NUM_SLOTS + FS_GRP - 1) / FS_GRP,
  localparam int unsigned GW        = (NGRP > 1) ? $clog2(NGRP) : 1,
  localparam int unsigned PADW      = NGRP * FS_GRP
) (
  input  logic                 clk_i,
  input  logic [NUM_SLOTS-1:0] busy_i,
  output logic [SLOT_W-1:0]    free_slot_o,
  output logic                 free_found_o
);

  logic [PADW+NUM_SLOTS-1:0] free_wide;
  logic [PADW-1:0]           free_pad;
  logic [NGRP-1:0]           grp_any_q;
  logic [FS_GRP_W-1:0]       grp_idx_q [NGRP];
  logic [NGRP-1:0]           grp_low;
  logic [GW+FS_GRP_W-1:0]    sel;
  logic [GW+FS_GRP_W+SLOT_W-1:0] sel_wide;

  // slot 0 is never handed out; padding slots count as taken
  assign free_wide = {{PADW{1'b0}}, ~busy_i[NUM_SLOTS-1:1], 1'b0};
  assign free_pad  = free_wide[PADW-1:0];

  // first level: per group any-free flag and lowest free position
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NGRP; g++) begin
      logic [FS_GRP-1:0]   grp;
      logic [FS_GRP-1:0]   low;
      logic [FS_GRP_W-1:0] idx;
      grp = free_pad[g*FS_GRP +: FS_GRP];
      low = grp & (~grp + FS_GRP'(1));
      idx = '0;
      for (int i = 0; i < FS_GRP; i++) begin
        if (low[i]) begin
          idx = idx | FS_GRP_W'(i);
        end
      end
      grp_any_q[g] <= |grp;
      grp_idx_q[g] <= idx;
    end
  end

  // second level: lowest group with a free slot
  assign grp_low = grp_any_q & (~grp_any_q + NGRP'(1));

  always_comb begin
    sel = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_low[g]) begin
        sel = sel | {GW'(g), grp_idx_q[g]};
      end
    end
  end

  assign sel_wide     = {{SLOT_W{1'b0}}, sel};
  assign free_slot_o  = sel_wide[SLOT_W-1:0];
  assign free_found_o = |grp_any_q;

endmodule

// File: design/refcounted_descriptor_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_descriptor_table
// descriptor table with shared, reference-counted info slots
// ----------------------------------------------------------------------------
// Each descriptor (0 .. NUM_FDS-1) maps to nothing or to an info slot
// (1 .. NUM_FDS) holding a reference count, open flags and a path hash; each
// descriptor also keeps its own close-on-exec bit. Actions are open (lowest
// free slot, count 1), duplicate (share a slot, count + 1), find, set
// close-on-exec and close (count - 1, unmap). Every accepted transfer gives
// exactly one result transfer, describing desc after the action. From
// acceptance to result, the descriptor memory read is issued with the
// request and lands at the accepting edge, the dependent slot memory read
// lands at the end of the descriptor step, and the write-back with the
// result register load happens at the end of the execute step. A new item
// is taken only in the idle state after that write-back, so items do not
// overlap, paced by the two dependent memory reads. The result register lets
// a new item enter while the last result is still waiting; a stalled result
// holds the following item before its write-back. The free slot search is a
// two-level registered priority tree over the slot busy bits and runs during
// the descriptor read. Reset clears the valid and busy bits at once; there
// is no clearing pass.
// ----------------------------------------------------------------------------
module refcounted_descriptor_table import rdt_pkg::*; #(
  parameter int unsigned NUM_FDS   = 64,
  parameter int unsigned HASH_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             action_i,
  input  logic [DESC_PORT_W-1:0] desc_i,
  input  logic [DESC_PORT_W-1:0] target_desc_i,
  input  logic [FLAGS_W-1:0]     open_flags_i,
  input  logic [HASH_PORT_W-1:0] name_hash_i,
  input  logic                   exec_close_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic                   found_o,
  output logic [NARROW_W-1:0]    slot_index_o,
  output logic [NARROW_W-1:0]    ref_count_o,
  output logic [FLAGS_W-1:0]     slot_flags_out_o,
  output logic [HASH_PORT_W-1:0] slot_hash_out_o,
  output logic                   exec_close_out_o
);

  localparam int unsigned NUM_SLOTS = NUM_FDS + 1;
  localparam int unsigned FD_W      = $clog2(NUM_FDS);
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam logic [DESC_PORT_W:0] NUM_FDS_C = (DESC_PORT_W + 1)'(NUM_FDS);

  state_e state_q, state_d;

  // captured request
  action_e                action_q;
  logic [DESC_PORT_W-1:0] d_q, t_q;
  logic [FLAGS_W-1:0]     flags_q;
  logic [HASH_BITS-1:0]   hash_q;
  logic                   ec_q;

  logic accept, go;

  // memory read addresses and data
  logic [FD_W-1:0]      desc_rd_a, desc_rd_b;
  logic [SLOT_W-1:0]    d_slot, t_slot;
  logic                 d_ec, t_ec;
  logic [SLOT_W-1:0]    s_cnt;
  logic [FLAGS_W-1:0]   s_flags;
  logic [HASH_BITS-1:0] s_hash;
  logic [NUM_SLOTS-1:0] busy;
  logic [SLOT_W-1:0]    free_slot;
  logic                 free_found;

  // write-back
  logic                 desc_we, desc_we_go;
  logic [FD_W-1:0]      desc_wr_addr;
  logic [SLOT_W-1:0]    desc_wr_slot;
  logic                 desc_wr_ec;
  logic                 slot_we, slot_we_go;
  logic [SLOT_W-1:0]    slot_wr_addr;
  logic [SLOT_W-1:0]    slot_wr_cnt;
  logic [FLAGS_W-1:0]   slot_wr_flags;
  logic [HASH_BITS-1:0] slot_wr_hash;

  // result of the item in progress
  status_e              rep_status;
  logic [SLOT_W-1:0]    rep_slot;
  logic [SLOT_W-1:0]    rep_cnt;
  logic [FLAGS_W-1:0]   rep_flags;
  logic [HASH_BITS-1:0] rep_hash;
  logic                 rep_ec;
  logic                 d_ok, t_ok, show;

  logic [SLOT_W+NARROW_W-1:0]       rep_slot_wide, rep_cnt_wide;
  logic [HASH_BITS+HASH_PORT_W-1:0] rep_hash_wide;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             status_q;
  logic                   found_q;
  logic [NARROW_W-1:0]    slot_index_q, ref_count_q;
  logic [FLAGS_W-1:0]     slot_flags_q;
  logic [HASH_PORT_W-1:0] slot_hash_q;
  logic                   exec_close_q;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DESC;
        end
      end
      S_DESC: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        // hold here until the result register can take the result
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    accept     = in_ready_o && in_valid_i;
    go         = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
    // read at the new request while idle, then hold the captured addresses
    // so that the read data stays put through a stall
    if (state_q == S_IDLE) begin
      desc_rd_a = desc_i[FD_W-1:0];
      desc_rd_b = target_desc_i[FD_W-1:0];
    end else begin
      desc_rd_a = d_q[FD_W-1:0];
      desc_rd_b = t_q[FD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_e'(action_i);
      d_q      <= desc_i;
      t_q      <= target_desc_i;
      flags_q  <= open_flags_i;
      hash_q   <= name_hash_i[HASH_BITS-1:0];
      ec_q     <= exec_close_i;
    end
  end

  // --------------------------------------------------------------------------
  // storage
  // --------------------------------------------------------------------------
  rdt_desc_mem #(
    .NUM_FDS (NUM_FDS),
    .SLOT_W  (SLOT_W)
  ) u_desc_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_a_addr_i (desc_rd_a),
    .rd_b_addr_i (desc_rd_b),
    .rd_a_slot_o (d_slot),
    .rd_a_ec_o   (d_ec),
    .rd_b_slot_o (t_slot),
    .rd_b_ec_o   (t_ec),
    .wr_en_i     (desc_we_go),
    .wr_addr_i   (desc_wr_addr),
    .wr_slot_i   (desc_wr_slot),
    .wr_ec_i     (desc_wr_ec)
  );

  // the slot read follows the slot index from the descriptor read
  rdt_slot_mem #(
    .NUM_FDS   (NUM_FDS),
    .HASH_BITS (HASH_BITS),
    .SLOT_W    (SLOT_W)
  ) u_slot_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (d_slot),
    .rd_cnt_o   (s_cnt),
    .rd_flags_o (s_flags),
    .rd_hash_o  (s_hash),
    .wr_en_i    (slot_we_go),
    .wr_addr_i  (slot_wr_addr),
    .wr_cnt_i   (slot_wr_cnt),
    .wr_flags_i (slot_wr_flags),
    .wr_hash_i  (slot_wr_hash),
    .busy_o     (busy)
  );

  rdt_free_search #(
    .NUM_FDS (NUM_FDS),
    .SLOT_W  (SLOT_W)
  ) u_free_search (
    .clk_i        (clk_i),
    .busy_i       (busy),
    .free_slot_o  (free_slot),
    .free_found_o (free_found)
  );

  // --------------------------------------------------------------------------
  // action decode and write-back; memory writes land on the go edge and the
  // next read is issued no earlier than the following edge, so no forwarding
  // --------------------------------------------------------------------------
  always_comb begin
    d_ok = ({1'b0, d_q} < NUM_FDS_C);
    t_ok = ({1'b0, t_q} < NUM_FDS_C);

    rep_status = ST_OK;
    rep_slot   = d_slot;
    rep_cnt    = s_cnt;
    rep_flags  = s_flags;
    rep_hash   = s_hash;
    rep_ec     = d_ec;

    desc_we       = 1'b0;
    desc_wr_addr  = d_q[FD_W-1:0];
    desc_wr_slot  = d_slot;
    desc_wr_ec    = d_ec;
    slot_we       = 1'b0;
    slot_wr_addr  = d_slot;
    slot_wr_cnt   = s_cnt;
    slot_wr_flags = s_flags;
    slot_wr_hash  = s_hash;

    if (action_q == ACT_DUP) begin
      // duplicate onto itself does nothing, valid or not
      if (d_q != t_q) begin
        if (!d_ok || !t_ok) begin
          rep_status = ST_BAD_DESC;
        end else if (d_slot != '0) begin
          if (t_slot != '0) begin
            rep_status = ST_DUP_BUSY;
          end else begin
            desc_we      = 1'b1;
            desc_wr_addr = t_q[FD_W-1:0];
            desc_wr_slot = d_slot;
            desc_wr_ec   = t_ec;
            slot_we      = 1'b1;
            slot_wr_cnt  = s_cnt + SLOT_W'(1);
            rep_cnt      = s_cnt + SLOT_W'(1);
          end
        end
      end
    end else if (!d_ok) begin
      rep_status = ST_BAD_DESC;
    end else begin
      case (action_q)
        ACT_OPEN: begin
          if (d_slot != '0) begin
            rep_status = ST_OPEN_BUSY;
          end else if (free_found) begin
            desc_we       = 1'b1;
            desc_wr_slot  = free_slot;
            desc_wr_ec    = 1'b0;
            slot_we       = 1'b1;
            slot_wr_addr  = free_slot;
            slot_wr_cnt   = SLOT_W'(1);
            slot_wr_flags = flags_q;
            slot_wr_hash  = hash_q;
            rep_slot      = free_slot;
            rep_cnt       = SLOT_W'(1);
            rep_flags     = flags_q;
            rep_hash      = hash_q;
            rep_ec        = 1'b0;
          end
        end
        ACT_SET_EC: begin
          if (d_slot != '0) begin
            desc_we    = 1'b1;
            desc_wr_ec = ec_q;
            rep_ec     = ec_q;
          end
        end
        ACT_CLOSE: begin
          if (d_slot != '0) begin
            // unmap but keep the close-on-exec bit
            desc_we      = 1'b1;
            desc_wr_slot = '0;
            slot_we      = 1'b1;
            if (s_cnt != '0) begin
              slot_wr_cnt = s_cnt - SLOT_W'(1);
            end
            rep_slot = '0;
          end
        end
        default: begin
          // find, and unknown actions behave as find
        end
      endcase
    end

    desc_we_go = desc_we && go;
    slot_we_go = slot_we && go;
    show       = d_ok && (rep_slot != '0);
  end

  assign rep_slot_wide = {{NARROW_W{1'b0}}, rep_slot};
  assign rep_cnt_wide  = {{NARROW_W{1'b0}}, rep_cnt};
  assign rep_hash_wide = {{HASH_PORT_W{1'b0}}, rep_hash};

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_comb begin
    if (go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // unmapped or invalid descriptors report zero apart from status
  always_ff @(posedge clk_i) begin
    if (go) begin
      status_q     <= rep_status;
      found_q      <= show;
      slot_index_q <= show ? rep_slot_wide[NARROW_W-1:0] : '0;
      ref_count_q  <= show ? rep_cnt_wide[NARROW_W-1:0] : '0;
      slot_flags_q <= show ? rep_flags : '0;
      slot_hash_q  <= show ? rep_hash_wide[HASH_PORT_W-1:0] : '0;
      exec_close_q <= show & rep_ec;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_o          = found_q;
  assign slot_index_o     = slot_index_q;
  assign ref_count_o      = ref_count_q;
  assign slot_flags_out_o = slot_flags_q;
  assign slot_hash_out_o  = slot_hash_q;
  assign exec_close_out_o = exec_close_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // an open that commits always has a free slot to take
  a_open_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_we_go && (action_q == ACT_OPEN)) |-> free_found)
    else $error("open committed without a free slot");

  // slot 0 means unmapped and is never written
  a_no_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_we_go |-> (slot_wr_addr != '0))
    else $error("write to reserved slot 0");

  // a count never exceeds the number of descriptors
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_we_go |-> ({1'b0, slot_wr_cnt} <= (SLOT_W + 1)'(NUM_FDS)))
    else $error("reference count out of range");

  // an accepted transfer starts the descriptor read
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DESC))
    else $error("accepted transfer did not start the read");

  // a result is loaded exactly when an item leaves the execute step
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("result not loaded on completion");

endmodule
